// ===== rtl/lpoq_pkg.sv =====
// lpoq_pkg: shared types and codes for the LRU page order queue.
// Used by lpoq_cell and lru_page_order_queue; depends on nothing.
`default_nettype none

package lpoq_pkg;

    localparam int REQ_PAGE_BITS = 16;
    localparam int RSP_COUNT_BITS = 7;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_TOUCH = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic [REQ_PAGE_BITS-1:0] page;
    } t_req;

    typedef struct packed {
        logic [REQ_PAGE_BITS-1:0]  popped_page;
        logic [1:0]                status;
        logic [RSP_COUNT_BITS-1:0] entry_count;
        logic                      is_empty;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_SHIFT = 2'd1,
        OP_LOAD  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/lru_page_order_queue.sv =====
// lru_page_order_queue: top level; a row of lpoq_cell slots, front at cell 0.
// Depends on lpoq_pkg and lpoq_cell.
//
// Usage:
//   Requests enter on i_valid/o_ready with i_req {command, page}; responses
//   leave on o_valid/i_ready with o_rsp {popped_page, status, entry_count,
//   is_empty}. Exactly one response per request, in order.
//   Push appends at the back, pop returns the front, touch moves the oldest
//   matching page to the back (status not-found if absent).
//   Each request passes through an accept step, whose edge registers a
//   compare in every cell, and an execute step (S_EXEC), whose edge applies
//   the shift/load across the row and registers the response. o_ready is
//   low in S_EXEC, so a new request waits until the previous one executes.
//   A new request is accepted while the previous response waits.
//   When the receiver stalls with a response pending, the next request
//   waits in the execute step until the output register frees.
//   Reset (synchronous, active low) empties the queue and drops any
//   pending response; slot contents are not cleared.
`default_nettype none

module lru_page_order_queue import lpoq_pkg::*; #(
    parameter int CAPACITY  = 64,
    parameter int PAGE_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LOGC = $clog2(CAPACITY);
    localparam int MINW = (PAGE_BITS < REQ_PAGE_BITS) ? PAGE_BITS : REQ_PAGE_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [1:0]             r_cmd;
    logic [PAGE_BITS-1:0]   r_page;
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_rsp, n_rsp;

    logic [PAGE_BITS-1:0]   w_in_page;
    logic [PAGE_BITS-1:0]   w_page;
    logic                   w_accept;
    logic                   w_go;
    logic [CAPACITY-1:0]    w_raw_match;
    logic [CAPACITY-1:0]    w_match;
    logic [CAPACITY-1:0]    w_prefix;
    logic                   w_hit;
    logic [PAGE_BITS-1:0]   w_data [CAPACITY];
    t_cell_ctl              w_ctl  [CAPACITY];

    always_comb begin
        w_in_page = '0;
        w_in_page[MINW-1:0] = i_req.page[MINW-1:0];
    end

    assign o_ready  = r_state[0];
    assign w_accept = i_valid && o_ready;
    assign w_go     = r_state[1] && (!r_out_valid || i_ready);
    assign w_page   = w_accept ? w_in_page : r_page;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            lpoq_cell #(
                .PAGE_BITS(PAGE_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[g]),
                .i_next ((g == CAPACITY - 1) ? {PAGE_BITS{1'b0}} : w_data[(g + 1) % CAPACITY]),
                .i_page (w_page),
                .o_data (w_data[g]),
                .o_match(w_raw_match[g])
            );
            assign w_match[g] = w_raw_match[g] && (CW'(g) < r_count);
        end
    endgenerate

    always_comb begin
        w_prefix = w_match;
        for (int s = 0; s < LOGC; s++) begin
            w_prefix = w_prefix | (w_prefix << (1 << s));
        end
    end
    assign w_hit = w_prefix[CAPACITY-1];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i].cmp_en = w_accept;
            w_ctl[i].op     = OP_HOLD;
            if (w_go) begin
                case (r_cmd)
                    CMD_PUSH: begin
                        if (r_count == CW'(i)) begin
                            w_ctl[i].op = OP_LOAD;
                        end
                    end
                    CMD_POP: begin
                        if (r_count != '0) begin
                            w_ctl[i].op = OP_SHIFT;
                        end
                    end
                    CMD_TOUCH: begin
                        if (w_hit) begin
                            if (r_count == CW'(i + 1)) begin
                                w_ctl[i].op = OP_LOAD;
                            end else if (w_prefix[i] && (CW'(i + 1) < r_count)) begin
                                w_ctl[i].op = OP_SHIFT;
                            end
                        end
                    end
                    default: w_ctl[i].op = OP_HOLD;
                endcase
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_rsp       = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state           = S_IDLE;
                    n_out_valid       = 1'b1;
                    n_rsp.popped_page = '0;
                    n_rsp.status      = ST_OK;
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_rsp.popped_page[MINW-1:0] = w_data[0][MINW-1:0];
                            end
                        end
                        CMD_TOUCH: begin
                            if (!w_hit) begin
                                n_rsp.status = ST_ABSENT;
                            end
                        end
                        default: n_rsp.status = ST_OK;
                    endcase
                    n_rsp.entry_count = RSP_COUNT_BITS'(n_count);
                    n_rsp.is_empty    = (n_count == '0);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_cmd  <= i_req.command;
            r_page <= w_in_page;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/lpoq_cell.sv =====
// lpoq_cell: one queue slot; holds a page, shifts from its back neighbor,
// loads a new page, and registers a compare against the request page. Uses lpoq_pkg.
`default_nettype none

module lpoq_cell import lpoq_pkg::*; #(
    parameter int PAGE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [PAGE_BITS-1:0] i_next,
    input  wire logic [PAGE_BITS-1:0] i_page,
    output logic      [PAGE_BITS-1:0] o_data,
    output logic                      o_match
);

    logic [PAGE_BITS-1:0] r_data;
    logic                 r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_SHIFT: r_data <= i_next;
            OP_LOAD:  r_data <= i_page;
            default:  r_data <= r_data;
        endcase
        if (i_ctl.cmp_en) begin
            r_match <= (r_data == i_page);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire
